@@ src/interaction_torque_pid_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Interaction torque PID unit - assertion macros
// Shared macros for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef INTERACTION_TORQUE_PID_UNIT_DEFINES_SVH
`define INTERACTION_TORQUE_PID_UNIT_DEFINES_SVH

// Check a property on every rising edge outside reset
`define ITPID_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define ITPID_ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/itpid_pkg.sv @@
// ----------------------------------------------------------------------------
// Interaction torque PID package
// Widths, codes, pipeline structs and the clear threshold helper.
// ----------------------------------------------------------------------------
package itpid_pkg;

	localparam int unsigned DATA_W              = 16;
	localparam int unsigned PERIOD_W            = 12;
	localparam int unsigned CNT_W               = 21;
	localparam int unsigned CFG_IDX_W           = 2;
	localparam int unsigned CFG_DATA_W          = 16;
	localparam int unsigned SPRING_PERIOD_S     = 60;
	localparam int unsigned CONTROL_RATE_HZ_DEF = 400;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Operating modes carried by each input word
	localparam logic [1:0] MODE_SPRING = 2'd0;
	localparam logic [1:0] MODE_TRANS  = 2'd1;
	localparam logic [1:0] MODE_IDLE   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_PERIOD = 2'd3;

	// Per-stage load strobes from the pipeline control
	typedef struct packed {
		logic take_s1;
		logic take_s2;
		logic take_s3;
		logic take_out;
	} ctl_t;

	// Live configuration seen by the datapath
	typedef struct packed {
		logic [DATA_W-1:0] prop_gain;
		logic [DATA_W-1:0] deriv_gain;
		logic [DATA_W-1:0] integ_gain;
		logic [CNT_W-1:0]  thr_trans;
	} cfg_t;

	// Error stage result
	typedef struct packed {
		logic signed [DATA_W-1:0] err;
		logic signed [DATA_W:0]   derr;
		logic signed [31:0]       integ;
		logic                     active;
		logic                     cleared;
	} s2_t;

	// Product stage result
	typedef struct packed {
		logic signed [32:0] prod_p;
		logic signed [33:0] prod_d;
		logic signed [48:0] prod_i;
		logic               active;
		logic               cleared;
	} s3_t;

	// Tick count at which the integral clears, clamped to the counter range
	function automatic logic [CNT_W-1:0] thr_clamp(input int unsigned rate,
	                                               input logic [PERIOD_W-1:0] period);
		logic [31:0] prod;
		prod = 32'(rate) * 32'(period);
		if (prod > 32'(CNT_MAX)) begin
			return CNT_MAX;
		end
		return prod[CNT_W-1:0];
	endfunction

endpackage

@@ src/itpid_front.sv @@
// ----------------------------------------------------------------------------
// Interaction torque PID - input and error stage
// Registers the input word, forms the error, updates the integral and
// previous error for active words and the tick counter once per word.
// ----------------------------------------------------------------------------
module itpid_front import itpid_pkg::*; #(
	parameter int unsigned CONTROL_RATE_HZ = CONTROL_RATE_HZ_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl,
	input  cfg_t                     cfg,
	input  logic                     cnt_clr,
	input  logic [1:0]               mode,
	input  logic signed [DATA_W-1:0] measured_torque,
	input  logic signed [DATA_W-1:0] interaction_target,
	output s2_t                      s2
);

	localparam logic [CNT_W-1:0] THR_SPRING =
		thr_clamp(CONTROL_RATE_HZ, PERIOD_W'(SPRING_PERIOD_S));

	logic [1:0]               mode_s1;
	logic signed [DATA_W-1:0] torque_s1;
	logic signed [DATA_W-1:0] target_s1;

	logic signed [DATA_W-1:0] prev_err_q;
	logic signed [31:0]       integ_q;
	logic [CNT_W-1:0]         cnt_q;

	logic signed [DATA_W:0]   diff;
	logic signed [DATA_W-1:0] err;
	logic signed [DATA_W:0]   derr;
	logic signed [31:0]       integ_next;
	logic [CNT_W-1:0]         cnt_inc;
	logic [CNT_W-1:0]         thr;
	logic                     active;
	logic                     hit;

	function automatic logic signed [DATA_W-1:0] sat16(input logic signed [DATA_W:0] v);
		if (v > 17'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -17'sd32768) begin
			return 16'sh8000;
		end
		return v[DATA_W-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return v[31:0];
	endfunction

	// Capture the incoming word
	always_ff @(posedge clk) begin
		if (ctl.take_s1) begin
			mode_s1   <= mode;
			torque_s1 <= measured_torque;
			target_s1 <= interaction_target;
		end
	end

	// Error, difference, integral and counter for the word in stage 1
	always_comb begin
		diff = (mode_s1 == MODE_SPRING) ? 17'(torque_s1) - 17'(target_s1) : 17'(torque_s1);
		err        = sat16(diff);
		derr       = 17'(err) - 17'(prev_err_q);
		integ_next = sat32(33'(integ_q) + 33'(err));
		cnt_inc    = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
		thr        = (mode_s1 == MODE_SPRING) ? THR_SPRING : cfg.thr_trans;
		active     = (mode_s1 == MODE_SPRING) || (mode_s1 == MODE_TRANS);
		hit        = active && (cnt_inc >= thr);
	end

	// Advance the controller state as the word leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
			cnt_q      <= '0;
		end else if (cnt_clr) begin
			cnt_q <= '0;
		end else if (ctl.take_s2) begin
			cnt_q <= hit ? '0 : cnt_inc;
			if (active) begin
				prev_err_q <= err;
				integ_q    <= hit ? '0 : integ_next;
			end
		end
	end

	// Hand the error terms on
	always_ff @(posedge clk) begin
		if (ctl.take_s2) begin
			s2.err     <= err;
			s2.derr    <= derr;
			s2.integ   <= integ_next;
			s2.active  <= active;
			s2.cleared <= hit;
		end
	end

endmodule

@@ src/itpid_mult.sv @@
// ----------------------------------------------------------------------------
// Interaction torque PID - product stage
// Multiplies error, error difference and integral by their gains.
// ----------------------------------------------------------------------------
module itpid_mult import itpid_pkg::*; (
	input  logic clk,
	input  ctl_t ctl,
	input  cfg_t cfg,
	input  s2_t  s2,
	output s3_t  s3
);

	logic signed [DATA_W:0] kp;
	logic signed [DATA_W:0] kd;
	logic signed [DATA_W:0] ki;

	// Gains are unsigned: widen with a zero sign bit
	assign kp = {1'b0, cfg.prop_gain};
	assign kd = {1'b0, cfg.deriv_gain};
	assign ki = {1'b0, cfg.integ_gain};

	// Register the three products
	always_ff @(posedge clk) begin
		if (ctl.take_s3) begin
			s3.prod_p  <= s2.err * kp;
			s3.prod_d  <= s2.derr * kd;
			s3.prod_i  <= s2.integ * ki;
			s3.active  <= s2.active;
			s3.cleared <= s2.cleared;
		end
	end

endmodule

@@ src/itpid_out.sv @@
// ----------------------------------------------------------------------------
// Interaction torque PID - sum and output stage
// Aligns and sums the products, rounds to Q8.8, saturates and holds
// the result word.
// ----------------------------------------------------------------------------
module itpid_out import itpid_pkg::*; (
	input  logic                     clk,
	input  ctl_t                     ctl,
	input  s3_t                      s3,
	output logic signed [DATA_W-1:0] cmd_q,
	output logic                     cleared_q
);

	logic signed [34:0] pd_sum;
	logic signed [49:0] acc;
	logic signed [33:0] scaled;
	logic signed [DATA_W-1:0] cmd;

	// Sum with half-LSB rounding, floor by taking the upper bits
	always_comb begin
		pd_sum = 35'(s3.prod_p) + 35'(s3.prod_d);
		acc    = (50'(pd_sum) <<< 8) + 50'(s3.prod_i) + 50'sd32768;
		scaled = acc[49:16];
		if (!s3.active) begin
			cmd = '0;
		end else if (scaled > 34'sd32767) begin
			cmd = 16'sh7FFF;
		end else if (scaled < -34'sd32768) begin
			cmd = 16'sh8000;
		end else begin
			cmd = scaled[DATA_W-1:0];
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (ctl.take_out) begin
			cmd_q     <= cmd;
			cleared_q <= s3.cleared;
		end
	end

endmodule

@@ src/interaction_torque_pid_unit.sv @@
// ----------------------------------------------------------------------------
// Interaction torque PID unit - top level
// One PID tick per input word: takes a word every cycle unless in_stall is
// high, and passes its result word through the input, error, product and
// output registers. The rate is set by the error stage, which updates the
// previous error, saturating integral and tick counter once per word;
// products and the final sum each take a further registered stage.
// Configuration writes take effect on the next edge.
// ----------------------------------------------------------------------------
module interaction_torque_pid_unit import itpid_pkg::*; #(
	parameter int unsigned CONTROL_RATE_HZ = CONTROL_RATE_HZ_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic signed [DATA_W-1:0] measured_torque,
	input  logic signed [DATA_W-1:0] interaction_target,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] torque_command,
	output logic                     integral_cleared
);

	localparam logic [CNT_W-1:0] THR_RESET =
		thr_clamp(CONTROL_RATE_HZ, PERIOD_W'(SPRING_PERIOD_S));

	logic [DATA_W-1:0]   prop_gain_q;
	logic [DATA_W-1:0]   deriv_gain_q;
	logic [DATA_W-1:0]   integ_gain_q;
	logic [PERIOD_W-1:0] period_q;
	logic [CNT_W-1:0]    thr_trans_q;
	logic                cnt_clr;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;
	logic ld_s1;
	logic ld_s2;
	logic ld_s3;
	logic ld_out;

	ctl_t ctl;
	cfg_t cfg;
	s2_t  s2;
	s3_t  s3;

	// Configuration registers; a changed period restarts the tick count
	assign cnt_clr = cfg_write && (cfg_index == CFG_RESET_PERIOD) &&
	                 (cfg_data[PERIOD_W-1:0] != period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= 16'd256;
			deriv_gain_q <= '0;
			integ_gain_q <= '0;
			period_q     <= PERIOD_W'(SPRING_PERIOD_S);
			thr_trans_q  <= THR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				CFG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				CFG_INTEG_GAIN: integ_gain_q <= cfg_data;
				CFG_RESET_PERIOD: begin
					period_q    <= cfg_data[PERIOD_W-1:0];
					thr_trans_q <= thr_clamp(CONTROL_RATE_HZ, cfg_data[PERIOD_W-1:0]);
				end
				default: ;
			endcase
		end
	end

	assign cfg.prop_gain  = prop_gain_q;
	assign cfg.deriv_gain = deriv_gain_q;
	assign cfg.integ_gain = integ_gain_q;
	assign cfg.thr_trans  = thr_trans_q;

	// Pipeline flow: a stage loads when empty or when its word moves on
	assign ld_out   = !out_valid_q || !out_stall;
	assign ld_s3    = !valid_s3 || ld_out;
	assign ld_s2    = !valid_s2 || ld_s3;
	assign ld_s1    = !valid_s1 || ld_s2;
	assign in_stall = !ld_s1;

	assign ctl.take_s1  = in_valid && ld_s1;
	assign ctl.take_s2  = valid_s1 && ld_s2;
	assign ctl.take_s3  = valid_s2 && ld_s3;
	assign ctl.take_out = valid_s3 && ld_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) begin
				valid_s1 <= in_valid;
			end
			if (ld_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ld_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ld_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	itpid_front #(
		.CONTROL_RATE_HZ(CONTROL_RATE_HZ)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.cfg               (cfg),
		.cnt_clr           (cnt_clr),
		.mode              (mode),
		.measured_torque   (measured_torque),
		.interaction_target(interaction_target),
		.s2                (s2)
	);

	itpid_mult u_mult (
		.clk(clk),
		.ctl(ctl),
		.cfg(cfg),
		.s2 (s2),
		.s3 (s3)
	);

	itpid_out u_out (
		.clk      (clk),
		.ctl      (ctl),
		.s3       (s3),
		.cmd_q    (torque_command),
		.cleared_q(integral_cleared)
	);

	assign out_valid = out_valid_q;

endmodule

@@ src/itpid_checker.sv @@
// ----------------------------------------------------------------------------
// Interaction torque PID unit - port checker
// Checks reset, output hold and back-pressure behaviour seen at the ports.
// ----------------------------------------------------------------------------
`include "interaction_torque_pid_unit_defines.svh"

module itpid_checker import itpid_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] torque_command,
	input logic                     integral_cleared
);

	// No result word is offered while reset is held
	`ITPID_ASSERT_RST(a_rst_no_out, clk, !arst_n |-> !out_valid, "out_valid during reset")

	// A stalled result word holds
	`ITPID_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(torque_command) && $stable(integral_cleared), "stalled result word changed")

	// Input back-pressure only arises from a stalled, full output
	`ITPID_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall, "input stalled without output back-pressure")

	// After a stalled input word the output word is still offered in the next cycle
	`ITPID_ASSERT(a_stall_keep, clk, arst_n, in_valid && in_stall |=> out_valid, "output dropped while input stalled")

endmodule

bind interaction_torque_pid_unit itpid_checker u_itpid_checker (.*);

@@ dv/interaction_torque_pid_checker.sv @@
// ----------------------------------------------------------------------------
// Interaction torque PID unit - result checker
// Watches the configuration port and both word channels, predicts the
// command word of each accepted input word, and compares every delivered
// word against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module interaction_torque_pid_checker import itpid_pkg::*; #(
	parameter int unsigned CONTROL_RATE_HZ = CONTROL_RATE_HZ_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [1:0]               mode,
	input  logic signed [DATA_W-1:0] measured_torque,
	input  logic signed [DATA_W-1:0] interaction_target,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DATA_W-1:0] torque_command,
	input  logic                     integral_cleared,
	output int                       mismatches,
	output int                       pending
);

	typedef struct packed {
		logic signed [DATA_W-1:0] cmd;
		logic                     cleared;
	} command_word_t;

	command_word_t pending_cmds[$];
	command_word_t oldest;

	// Shadow copy of the registers
	logic [DATA_W-1:0]   kp;
	logic [DATA_W-1:0]   kd;
	logic [DATA_W-1:0]   ki;
	logic [PERIOD_W-1:0] clear_period;

	// Controller state
	logic signed [DATA_W-1:0] last_err;
	logic signed [31:0]       integ_acc;
	logic [CNT_W-1:0]         tick_cnt;

	// Run one control tick and return the command word it produces
	function automatic command_word_t pid_tick(input logic [1:0] m,
	                                           input logic signed [DATA_W-1:0] tq,
	                                           input logic signed [DATA_W-1:0] tg);
		longint err;
		longint derr;
		longint integ;
		longint acc;
		longint cmd;
		longint thr;
		command_word_t w;
		w = '0;
		if (tick_cnt != CNT_MAX) begin
			tick_cnt = tick_cnt + 1'b1;
		end
		// idle and the undefined mode only advance the counter
		if (m != MODE_SPRING && m != MODE_TRANS) begin
			return w;
		end
		err = (m == MODE_SPRING) ? longint'(tq) - longint'(tg) : longint'(tq);
		if (err > 32767) begin
			err = 32767;
		end else if (err < -32768) begin
			err = -32768;
		end
		derr = err - longint'(last_err);
		// integral takes this error before the sum is formed
		integ = longint'(integ_acc) + err;
		if (integ > 64'sd2147483647) begin
			integ = 64'sd2147483647;
		end else if (integ < -64'sd2147483648) begin
			integ = -64'sd2147483648;
		end
		integ_acc = 32'(integ);
		acc = (err * longint'(kp) + derr * longint'(kd)) * 256 + integ * longint'(ki);
		// round half up to Q8.8, then saturate
		cmd = (acc + 32768) >>> 16;
		if (cmd > 32767) begin
			cmd = 32767;
		end else if (cmd < -32768) begin
			cmd = -32768;
		end
		last_err = 16'(err);
		thr = longint'(CONTROL_RATE_HZ) *
		      ((m == MODE_SPRING) ? longint'(SPRING_PERIOD_S) : longint'(clear_period));
		if (thr > longint'(CNT_MAX)) begin
			thr = longint'(CNT_MAX);
		end
		if (longint'(tick_cnt) >= thr) begin
			integ_acc = '0;
			tick_cnt  = '0;
			w.cleared = 1'b1;
		end
		w.cmd = 16'(cmd);
		return w;
	endfunction

	// Count a fault, print only the first few
	task automatic log_fault(input string what);
		if (mismatches < 10) begin
			$display("%0t: %s", $realtime, what);
		end
		mismatches++;
	endtask

	// Track registers, predict on accepted words, compare delivered words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp           = 16'd256;
			kd           = '0;
			ki           = '0;
			clear_period = 12'd60;
			last_err     = '0;
			integ_acc    = '0;
			tick_cnt     = '0;
			pending_cmds.delete();
			mismatches   = 0;
			pending      = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_PROP_GAIN: begin
						kp = cfg_data;
					end
					CFG_DERIV_GAIN: begin
						kd = cfg_data;
					end
					CFG_INTEG_GAIN: begin
						ki = cfg_data;
					end
					CFG_RESET_PERIOD: begin
						// a new period restarts the tick count
						if (cfg_data[PERIOD_W-1:0] != clear_period) begin
							clear_period = cfg_data[PERIOD_W-1:0];
							tick_cnt     = '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				pending_cmds.push_back(pid_tick(mode, measured_torque, interaction_target));
			end
			if (out_valid && !out_stall) begin
				if (pending_cmds.size() == 0) begin
					log_fault($sformatf("unexpected word: cmd %0d cleared %0b",
					                    torque_command, integral_cleared));
				end else begin
					oldest = pending_cmds.pop_front();
					if (oldest.cmd !== torque_command || oldest.cleared !== integral_cleared) begin
						log_fault($sformatf("mismatch: expected cmd %0d cleared %0b, got cmd %0d cleared %0b",
						                    oldest.cmd, oldest.cleared,
						                    torque_command, integral_cleared));
					end
				end
			end
			pending = pending_cmds.size();
		end
	end

endmodule

@@ dv/interaction_torque_pid_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Interaction torque PID unit - testbench
// Drives directed and random control ticks through several register
// settings and idling profiles, and holds the output off to back the unit
// up. The checker predicts and compares every word.
// ----------------------------------------------------------------------------
module interaction_torque_pid_unit_tb import itpid_pkg::*;;

	localparam int unsigned RATE_HZ     = CONTROL_RATE_HZ_DEF;
	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam logic [1:0]  MODE_UNDEF  = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               mode;
	logic signed [DATA_W-1:0] measured_torque;
	logic signed [DATA_W-1:0] interaction_target;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] torque_command;
	logic                     integral_cleared;

	int   mismatches;
	int   pending;
	int   cycles = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;

	interaction_torque_pid_unit #(.CONTROL_RATE_HZ(RATE_HZ)) uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.mode               (mode),
		.measured_torque    (measured_torque),
		.interaction_target (interaction_target),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.torque_command     (torque_command),
		.integral_cleared   (integral_cleared)
	);

	interaction_torque_pid_checker #(.CONTROL_RATE_HZ(RATE_HZ)) cmd_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.mode               (mode),
		.measured_torque    (measured_torque),
		.interaction_target (interaction_target),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.torque_command     (torque_command),
		.integral_cleared   (integral_cleared),
		.mismatches         (mismatches),
		.pending            (pending)
	);

	always #5 clk = ~clk;

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one word, with random idle cycles first, and wait for acceptance
	task automatic send_word(input logic [1:0] m, input logic signed [DATA_W-1:0] tq,
	                         input logic signed [DATA_W-1:0] tg);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid           <= 1'b1;
		mode               <= m;
		measured_torque    <= tq;
		interaction_target <= tg;
		do begin
			@(posedge clk);
		end while (in_stall !== 1'b0);
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Half moderate torques, some extremes, the rest fully random
	function automatic logic signed [DATA_W-1:0] pick_torque();
		int r;
		r = $urandom_range(99);
		if (r < 50) begin
			return 16'(int'($urandom_range(4095)) - 2048);
		end else if (r < 62) begin
			case ($urandom_range(3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				default: return -16'sd1;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		int r;
		r = $urandom_range(99);
		if (r < 15) begin
			return '0;
		end else if (r < 30) begin
			return '1;
		end else if (r < 85) begin
			return 16'($urandom_range(1023));
		end
		return 16'($urandom);
	endfunction

	task automatic send_random_word();
		int r;
		logic [1:0] m;
		r = $urandom_range(99);
		if (r < 45) begin
			m = MODE_SPRING;
		end else if (r < 85) begin
			m = MODE_TRANS;
		end else if (r < 95) begin
			m = MODE_IDLE;
		end else begin
			m = MODE_UNDEF;
		end
		send_word(m, pick_torque(), pick_torque());
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_index          = CFG_PROP_GAIN;
		cfg_data           = '0;
		in_valid           = 1'b0;
		mode               = MODE_IDLE;
		measured_torque    = '0;
		interaction_target = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset register values, every mode
		send_word(MODE_SPRING, 16'sd100, 16'sd50);
		send_word(MODE_TRANS, -16'sd300, 16'sd7);
		send_word(MODE_IDLE, 16'sd1234, -16'sd99);
		send_word(MODE_UNDEF, -16'sd1, 16'sd1);
		send_word(MODE_SPRING, -16'sd512, 16'sd256);
		settle();

		// Full gains; period of zero written with its unused top bits set
		write_reg(CFG_PROP_GAIN, '1);
		write_reg(CFG_DERIV_GAIN, '1);
		write_reg(CFG_INTEG_GAIN, '1);
		write_reg(CFG_RESET_PERIOD, 16'hF000);
		send_word(MODE_SPRING, 16'sd32767, -16'sd32768);
		send_word(MODE_SPRING, -16'sd32768, 16'sd32767);
		send_word(MODE_TRANS, 16'sd32767, 16'sd0);
		send_word(MODE_TRANS, -16'sd32768, 16'sd0);
		send_word(MODE_SPRING, 16'sd0, 16'sd0);
		send_word(MODE_TRANS, 16'sd0, -16'sd32768);
		send_word(MODE_IDLE, 16'sd32767, 16'sd32767);
		send_word(MODE_UNDEF, -16'sd32768, -16'sd32768);
		send_word(MODE_SPRING, -16'sd1, 16'sd0);
		send_word(MODE_SPRING, 16'sd32767, 16'sd32767);
		settle();

		// Zero gains: command must sit at zero
		write_reg(CFG_PROP_GAIN, '0);
		write_reg(CFG_DERIV_GAIN, '0);
		write_reg(CFG_INTEG_GAIN, '0);
		write_reg(CFG_RESET_PERIOD, 16'd1);
		send_word(MODE_SPRING, 16'sd32767, -16'sd32768);
		send_word(MODE_TRANS, -16'sd32768, 16'sd0);
		send_word(MODE_SPRING, 16'sd5, 16'sd3);

		// Random phases, each with its own registers and idling profile
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			write_reg(CFG_PROP_GAIN, (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : pick_gain());
			write_reg(CFG_DERIV_GAIN, (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : pick_gain());
			write_reg(CFG_INTEG_GAIN, (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : pick_gain());
			if (ph == 0) begin
				write_reg(CFG_RESET_PERIOD, {4'($urandom), 12'd4095});
			end else if (ph == 1) begin
				write_reg(CFG_RESET_PERIOD, {4'($urandom), 12'd0});
			end else if (ph == 2 || $urandom_range(1) == 0) begin
				write_reg(CFG_RESET_PERIOD, {4'($urandom), 12'($urandom_range(3))});
			end else begin
				write_reg(CFG_RESET_PERIOD, {4'($urandom), 12'($urandom_range(1, 4095))});
			end
			case (ph % 4)
				0: begin
					send_idle_pct <= 0;
					stall_pct     <= 0;
				end
				1: begin
					send_idle_pct <= 55;
					stall_pct     <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					stall_pct     <= 55;
				end
				default: begin
					send_idle_pct <= 22;
					stall_pct     <= 22;
				end
			endcase
			repeat (130) send_random_word();
		end

		// Back the unit up behind a long output hold-off
		settle();
		send_idle_pct <= 0;
		stall_pct     <= 0;
		hold_req      <= 1'b1;
		repeat (40) send_random_word();
		settle();

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
